>>> rtl/trcw_pkg.sv
// Package for the TCP Reno congestion window block.
// Holds shared widths, phase codes, sequencer states and the saturating add.
// No dependencies.
`default_nettype none

package trcw_pkg;

    localparam int SEQ_W  = 32;
    localparam int MSS_W  = 16;
    localparam int DIV_W  = 32;
    localparam int CFG_AW = 2;

    localparam logic [1:0] PH_SLOW_START = 2'd0;
    localparam logic [1:0] PH_AVOIDANCE  = 2'd1;
    localparam logic [1:0] PH_RECOVERY   = 2'd2;

    localparam logic [CFG_AW-1:0] CFG_SEGMENT_SIZE      = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_INITIAL_WINDOW    = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_INITIAL_THRESHOLD = 2'd2;

    localparam logic [MSS_W-1:0] RST_SEGMENT_SIZE      = 16'd1460;
    localparam logic [SEQ_W-1:0] RST_INITIAL_WINDOW    = 32'd1460;
    localparam logic [SEQ_W-1:0] RST_INITIAL_THRESHOLD = 32'd65535;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_OUT
    } seq_state_t;

    function automatic logic [SEQ_W-1:0] sat_add(input logic [SEQ_W-1:0] a,
                                                 input logic [SEQ_W-1:0] b);
        logic [SEQ_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SEQ_W] ? {SEQ_W{1'b1}} : s[SEQ_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/trcw_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on trcw_pkg for the operand width.
`default_nettype none

module trcw_div import trcw_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [DIV_W-1:0] dividend,
    input  wire logic [DIV_W-1:0] divisor,
    output logic                  done,
    output logic [DIV_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(DIV_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_W - 1);

    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] dsr_reg, dsr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [DIV_W:0]   shifted;
    logic [DIV_W:0]   diff;

    always_comb begin
        shifted   = {rem_reg, quo_reg[DIV_W-1]};
        diff      = shifted - {1'b0, dsr_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[DIV_W]) begin
                rem_next = diff[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

>>> rtl/tcp_reno_congestion_window.sv
// Top level: TCP Reno congestion window tracker with its sequencer.
// Depends on trcw_pkg and trcw_div (iterative divider).
//
//  channel  dir  payload (lsb up)                                    handshake
//  s_       in   tuser: ack_present; tdata: ack_number,              tvalid/tready
//                oldest_unacked, next_send_seq
//  m_       out  tdata: window, threshold, phase, fast_retransmit    tvalid/tready
//  cfg_     in   wr_addr selects register, wr_data value             wr_en
//
// A new ACK in congestion avoidance also passes through ST_DIV, where the
// 32-step divider computes MSS*MSS/window.
// One word in flight; s_tready is high only while the sequencer is idle.
// The result register holds a word until taken; a stalled m_ side holds the
// sequencer in ST_OUT, so no new input word is taken either.
// Reset: synchronous, active low; state loads the reset register values.
`default_nettype none

module tcp_reno_congestion_window import trcw_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [95:0]       s_tdata,   // ack_number, oldest_unacked, next_send_seq
    input  wire logic              s_tuser,   // ack_present
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [71:0]            m_tdata,   // window, threshold, phase, fast_retransmit
    input  wire logic              cfg_wr_en,
    input  wire logic [CFG_AW-1:0] cfg_wr_addr,
    input  wire logic [SEQ_W-1:0]  cfg_wr_data
);

    seq_state_t       state_reg, state_next;

    logic [MSS_W-1:0] mss_reg, mss_next;
    logic [SEQ_W-1:0] init_win_reg, init_win_next;
    logic [SEQ_W-1:0] init_thr_reg, init_thr_next;

    logic [SEQ_W-1:0] win_reg, win_next;
    logic [SEQ_W-1:0] thr_reg, thr_next;
    logic [1:0]       phase_reg, phase_next;
    logic [1:0]       dup_reg, dup_next;
    logic [SEQ_W-1:0] rec_reg, rec_next;
    logic             fr_reg, fr_next;

    logic             ack_reg;
    logic [SEQ_W-1:0] ackn_reg, una_reg, nxt_reg;

    logic             m_valid_reg, m_valid_next;
    logic [71:0]      m_data_reg, m_data_next;

    logic             div_start;
    logic             div_done;
    logic [DIV_W-1:0] div_quo;
    logic [DIV_W-1:0] div_sq;
    logic [DIV_W-1:0] div_dsr;

    logic [SEQ_W-1:0] ack_diff, rec_diff;
    logic             is_new, is_dup, past_rec;
    logic [SEQ_W-1:0] mss_ext, mss3, win_grow, rec_base, rec_thr, rec_win;
    logic             s_take;

    assign s_take   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);

    assign mss_ext  = {{(SEQ_W-MSS_W){1'b0}}, mss_reg};
    assign mss3     = mss_ext + {mss_ext[SEQ_W-2:0], 1'b0};
    assign ack_diff = ackn_reg - una_reg;
    assign rec_diff = ackn_reg - rec_reg;
    assign is_new   = (ack_diff != '0) && !ack_diff[SEQ_W-1];
    assign is_dup   = (ack_diff == '0);
    assign past_rec = !rec_diff[SEQ_W-1];
    assign win_grow = sat_add(win_reg, mss_ext);
    assign rec_base = (phase_reg == PH_RECOVERY) ? win_grow : win_reg;
    assign rec_thr  = {1'b0, rec_base[SEQ_W-1:1]};
    assign rec_win  = sat_add(rec_thr, mss3);

    assign div_sq   = mss_ext * mss_ext;
    assign div_dsr  = (win_reg == '0) ? DIV_W'(1) : win_reg;

    trcw_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_sq),
        .divisor  (div_dsr),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb begin
        state_next    = state_reg;
        mss_next      = mss_reg;
        init_win_next = init_win_reg;
        init_thr_next = init_thr_reg;
        win_next      = win_reg;
        thr_next      = thr_reg;
        phase_next    = phase_reg;
        dup_next      = dup_reg;
        rec_next      = rec_reg;
        fr_next       = fr_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        div_start     = 1'b0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_take) begin
                    fr_next    = 1'b0;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                state_next = ST_OUT;
                if (ack_reg) begin
                    case (phase_reg)
                        PH_SLOW_START, PH_AVOIDANCE: begin
                            if (is_new) begin
                                if (phase_reg == PH_SLOW_START) begin
                                    win_next = win_grow;
                                    if (win_grow >= thr_reg) begin
                                        phase_next = PH_AVOIDANCE;
                                    end
                                end else begin
                                    div_start  = 1'b1;
                                    state_next = ST_DIV;
                                end
                            end else if (is_dup) begin
                                if (dup_reg == 2'd2) begin
                                    thr_next   = rec_thr;
                                    win_next   = rec_win;
                                    dup_next   = '0;
                                    rec_next   = nxt_reg;
                                    phase_next = PH_RECOVERY;
                                    fr_next    = 1'b1;
                                end else begin
                                    dup_next = dup_reg + 1'b1;
                                end
                            end
                        end
                        PH_RECOVERY: begin
                            if (is_new && past_rec) begin
                                win_next   = thr_reg;
                                dup_next   = '0;
                                phase_next = PH_AVOIDANCE;
                            end else if (is_new) begin
                                win_next = win_grow;
                            end else if (is_dup) begin
                                if (dup_reg == 2'd2) begin
                                    thr_next = rec_thr;
                                    win_next = rec_win;
                                    dup_next = '0;
                                    rec_next = nxt_reg;
                                    fr_next  = 1'b1;
                                end else begin
                                    win_next = win_grow;
                                    dup_next = dup_reg + 1'b1;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    win_next   = sat_add(win_reg, div_quo);
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {5'd0, fr_reg, phase_reg, thr_reg, win_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_wr_en) begin
            case (cfg_wr_addr)
                CFG_SEGMENT_SIZE: begin
                    mss_next = cfg_wr_data[MSS_W-1:0];
                end
                CFG_INITIAL_WINDOW: begin
                    init_win_next = cfg_wr_data;
                    win_next      = cfg_wr_data;
                end
                CFG_INITIAL_THRESHOLD: begin
                    init_thr_next = cfg_wr_data;
                    thr_next      = cfg_wr_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            ack_reg  <= s_tuser;
            ackn_reg <= s_tdata[31:0];
            una_reg  <= s_tdata[63:32];
            nxt_reg  <= s_tdata[95:64];
        end
        m_data_reg <= m_data_next;
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            mss_reg      <= RST_SEGMENT_SIZE;
            init_win_reg <= RST_INITIAL_WINDOW;
            init_thr_reg <= RST_INITIAL_THRESHOLD;
            win_reg      <= RST_INITIAL_WINDOW;
            thr_reg      <= RST_INITIAL_THRESHOLD;
            phase_reg    <= PH_SLOW_START;
            dup_reg      <= '0;
            rec_reg      <= '0;
            fr_reg       <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            mss_reg      <= mss_next;
            init_win_reg <= init_win_next;
            init_thr_reg <= init_thr_next;
            win_reg      <= win_next;
            thr_reg      <= thr_next;
            phase_reg    <= phase_next;
            dup_reg      <= dup_next;
            rec_reg      <= rec_next;
            fr_reg       <= fr_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

>>> tb/reno_window_checker.sv
// Checker for tcp_reno_congestion_window: follows config writes, predicts each result word
// from accepted input words and compares it field by field. Depends on trcw_pkg.
`timescale 1ns / 1ps

module reno_window_checker import trcw_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    input  wire logic              s_tready,
    input  wire logic [95:0]       s_tdata,
    input  wire logic              s_tuser,
    input  wire logic              m_tvalid,
    input  wire logic              m_tready,
    input  wire logic [71:0]       m_tdata,
    input  wire logic              cfg_wr_en,
    input  wire logic [CFG_AW-1:0] cfg_wr_addr,
    input  wire logic [SEQ_W-1:0]  cfg_wr_data,
    output int                     n_fail,
    output int                     n_pending
);

    typedef struct {
        logic [SEQ_W-1:0] window;
        logic [SEQ_W-1:0] threshold;
        logic [1:0]       phase;
        logic             fast_retransmit;
    } reno_result_t;

    logic [MSS_W-1:0] mss;
    logic [SEQ_W-1:0] cwnd;
    logic [SEQ_W-1:0] ssthresh;
    logic [SEQ_W-1:0] recover_seq;
    logic [1:0]       phase;
    logic [1:0]       dup_cnt;

    reno_result_t expected_windows[$];

    function automatic logic [SEQ_W-1:0] clamp_add(input logic [SEQ_W-1:0] a,
                                                   input logic [63:0] b);
        logic [64:0] s;
        s = {33'd0, a} + {1'b0, b};
        return (s[64:32] != '0) ? '1 : s[31:0];
    endfunction

    // wraparound order: a strictly after b / a at or after b
    function automatic logic seq_gt(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
        logic [SEQ_W-1:0] d;
        d = a - b;
        return (d != '0) && !d[SEQ_W-1];
    endfunction

    function automatic logic seq_ge(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
        logic [SEQ_W-1:0] d;
        d = a - b;
        return !d[SEQ_W-1];
    endfunction

    task automatic enter_fast_recovery(input logic [SEQ_W-1:0] nxt);
        ssthresh    = cwnd >> 1;
        cwnd        = clamp_add(ssthresh, {48'd0, mss} * 64'd3);
        dup_cnt     = '0;
        recover_seq = nxt;
        phase       = PH_RECOVERY;
    endtask

    task automatic reno_update(input logic ack, input logic [SEQ_W-1:0] ackn,
                               input logic [SEQ_W-1:0] una, input logic [SEQ_W-1:0] nxt,
                               output reno_result_t r);
        logic        is_new;
        logic        is_dup;
        logic [63:0] sq;
        logic [63:0] divisor;
        r.fast_retransmit = 1'b0;
        is_new = seq_gt(ackn, una);
        is_dup = (ackn == una);
        if (ack) begin
            case (phase)
                PH_SLOW_START, PH_AVOIDANCE: begin
                    if (is_new) begin
                        if (phase == PH_SLOW_START) begin
                            cwnd = clamp_add(cwnd, {48'd0, mss});
                            if (cwnd >= ssthresh)
                                phase = PH_AVOIDANCE;
                        end else begin
                            sq      = {48'd0, mss} * {48'd0, mss};
                            divisor = (cwnd == '0) ? 64'd1 : {32'd0, cwnd};
                            cwnd    = clamp_add(cwnd, sq / divisor);
                        end
                    end else if (is_dup) begin
                        dup_cnt++;
                        if (dup_cnt == 2'd3) begin
                            enter_fast_recovery(nxt);
                            r.fast_retransmit = 1'b1;
                        end
                    end
                end
                PH_RECOVERY: begin
                    if (is_new && seq_ge(ackn, recover_seq)) begin
                        cwnd    = ssthresh;
                        dup_cnt = '0;
                        phase   = PH_AVOIDANCE;
                    end else if (is_new) begin
                        cwnd = clamp_add(cwnd, {48'd0, mss});
                    end else if (is_dup) begin
                        cwnd = clamp_add(cwnd, {48'd0, mss});
                        dup_cnt++;
                        if (dup_cnt == 2'd3) begin
                            enter_fast_recovery(nxt);
                            r.fast_retransmit = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
        r.window    = cwnd;
        r.threshold = ssthresh;
        r.phase     = phase;
    endtask

    always @(posedge aclk) begin
        reno_result_t got;
        reno_result_t want;
        int           bad;
        bad = 0;
        if (!aresetn) begin
            mss         = RST_SEGMENT_SIZE;
            cwnd        = RST_INITIAL_WINDOW;
            ssthresh    = RST_INITIAL_THRESHOLD;
            phase       = PH_SLOW_START;
            dup_cnt     = '0;
            recover_seq = '0;
            expected_windows.delete();
            n_pending <= 0;
            n_fail    <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_wr_addr)
                    CFG_SEGMENT_SIZE: begin
                        mss = cfg_wr_data[MSS_W-1:0];
                    end
                    CFG_INITIAL_WINDOW: begin
                        cwnd = cfg_wr_data;
                    end
                    CFG_INITIAL_THRESHOLD: begin
                        ssthresh = cfg_wr_data;
                    end
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got.window          = m_tdata[31:0];
                got.threshold       = m_tdata[63:32];
                got.phase           = m_tdata[65:64];
                got.fast_retransmit = m_tdata[66];
                if (expected_windows.size() == 0) begin
                    $error("result word with nothing expected: %h", m_tdata);
                    bad++;
                end else begin
                    want = expected_windows.pop_front();
                    if (got.window !== want.window) begin
                        $error("window: expected %0d, got %0d", want.window, got.window);
                        bad++;
                    end
                    if (got.threshold !== want.threshold) begin
                        $error("threshold: expected %0d, got %0d", want.threshold,
                               got.threshold);
                        bad++;
                    end
                    if (got.phase !== want.phase) begin
                        $error("phase: expected %0d, got %0d", want.phase, got.phase);
                        bad++;
                    end
                    if (got.fast_retransmit !== want.fast_retransmit) begin
                        $error("fast_retransmit: expected %0d, got %0d",
                               want.fast_retransmit, got.fast_retransmit);
                        bad++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                reno_update(s_tuser, s_tdata[31:0], s_tdata[63:32], s_tdata[95:64], want);
                expected_windows.push_back(want);
            end
            n_pending <= expected_windows.size();
            n_fail    <= n_fail + bad;
        end
    end

endmodule

>>> tb/tb.sv
// Top of the testbench for tcp_reno_congestion_window: clock, reset, ACK stimulus,
// config writes and verdict. Depends on trcw_pkg, the RTL and reno_window_checker.
`timescale 1ns / 1ps

module tb;
    import trcw_pkg::*;

    localparam logic [CFG_AW-1:0] CFG_UNUSED = 2'd3;
    localparam int QUIET_LIMIT = 4000;

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              s_tvalid    = 1'b0;
    logic              s_tready;
    logic [95:0]       s_tdata     = '0;   // ack_number, oldest_unacked, next_send_seq
    logic              s_tuser     = 1'b0; // ack_present
    logic              m_tvalid;
    logic              m_tready    = 1'b0;
    logic [71:0]       m_tdata;            // window, threshold, phase, fast_retransmit
    logic              cfg_wr_en   = 1'b0;
    logic [CFG_AW-1:0] cfg_wr_addr = '0;
    logic [SEQ_W-1:0]  cfg_wr_data = '0;

    int n_fail;
    int n_pending;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int quiet_cycles  = 0;

    logic [SEQ_W-1:0] snd_una;
    logic [SEQ_W-1:0] snd_nxt;

    always #10 aclk = ~aclk;

    tcp_reno_congestion_window i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_addr (cfg_wr_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    reno_window_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_addr (cfg_wr_addr),
        .cfg_wr_data (cfg_wr_data),
        .n_fail      (n_fail),
        .n_pending   (n_pending)
    );

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_word(input logic ack, input logic [SEQ_W-1:0] ackn,
                             input logic [SEQ_W-1:0] una, input logic [SEQ_W-1:0] nxt);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= ack;
        s_tdata  <= {nxt, una, ackn};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // caller lowers cfg_wr_en once after the last write of a batch
    task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [SEQ_W-1:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_wr_addr <= addr;
        cfg_wr_data <= data;
        @(posedge aclk);
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (n_pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // one segment from a sender whose una/nxt advance; counts only new and duplicate ACKs
    task automatic send_random_segment(output int counted);
        logic [SEQ_W-1:0] adv;
        logic [SEQ_W-1:0] ackn;
        int               pick;
        counted = 0;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            case ($urandom_range(0, 9))
                0:       adv = snd_nxt - snd_una;
                1:       adv = $urandom_range(1, 32'h7FFF_FFFF);
                default: adv = $urandom_range(1, 4000);
            endcase
            if (adv == '0 || adv[SEQ_W-1])
                adv = 1;
            ackn = snd_una + adv;
            send_word(1'b1, ackn, snd_una, snd_nxt);
            snd_una = ackn;
            if ((snd_nxt - snd_una) >= 32'h8000_0000)
                snd_nxt = snd_una;
            snd_nxt = snd_nxt + $urandom_range(0, 6000);
            counted = 1;
        end else if (pick < 75) begin
            send_word(1'b1, snd_una, snd_una, snd_nxt);
            counted = 1;
        end else if (pick < 82) begin
            send_word(1'b1, snd_una - $urandom_range(1, 32'h8000_0000), snd_una, snd_nxt);
        end else if (pick < 90) begin
            send_word(1'b0, $urandom(), $urandom(), $urandom());
        end else begin
            send_word($urandom_range(0, 1), $urandom(), $urandom(), $urandom());
        end
    endtask

    initial begin
        int blk;
        int done;
        int counted;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        send_idle_pct = 8;
        stall_pct     = 8;
        @(posedge aclk);

        // reset register values
        send_word(1'b0, '1, '1, '1);
        send_word(1'b1, 32'd2460, 32'd1000, 32'd10000);
        send_word(1'b1, 32'd2460, 32'd2460, 32'd10000);
        send_word(1'b1, 32'd2000, 32'd2460, 32'd10000);
        send_word(1'b1, 32'd2460 + 32'h8000_0000, 32'd2460, 32'd10000);
        send_word(1'b1, 32'd0, 32'd0, 32'd0);
        wait_results_drained();
        write_reg(CFG_INITIAL_THRESHOLD, 32'd5000);
        cfg_wr_en <= 1'b0;

        // slow start into avoidance, then fast recovery entry, re-entry and exit
        send_word(1'b1, 32'd5000, 32'd2460, 32'd10000);
        send_word(1'b1, 32'd6000, 32'd5000, 32'd10000);
        send_word(1'b1, 32'd7000, 32'd6000, 32'd20000);
        send_word(1'b1, 32'd7000, 32'd7000, 32'd20000);
        send_word(1'b1, 32'd7000, 32'd7000, 32'd20000);
        send_word(1'b1, 32'd9000, 32'd7000, 32'd20000);
        send_word(1'b1, 32'd9000, 32'd9000, 32'd30000);
        send_word(1'b1, 32'd9000, 32'd9000, 32'd30000);
        send_word(1'b1, 32'd30000, 32'd9000, 32'd30000);
        wait_results_drained();

        // zero window in avoidance
        write_reg(CFG_INITIAL_WINDOW, 32'd0);
        cfg_wr_en <= 1'b0;
        send_word(1'b1, 32'd31000, 32'd30000, 32'd40000);
        wait_results_drained();

        // saturation with the largest segment size and window
        write_reg(CFG_SEGMENT_SIZE, 32'd65535);
        write_reg(CFG_INITIAL_WINDOW, 32'hFFFF_FFFF);
        write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
        cfg_wr_en <= 1'b0;
        send_word(1'b1, 32'd32000, 32'd31000, 32'd40000);
        repeat (4) send_word(1'b1, 32'd32000, 32'd32000, 32'd40000);
        send_word(1'b1, 32'hFFFF_FFFF, 32'd32000, 32'd40000);
        send_word(1'b1, 32'd40000, 32'd32000, 32'd40000);
        wait_results_drained();

        // zero segment size, widest forward step
        write_reg(CFG_SEGMENT_SIZE, 32'd0);
        cfg_wr_en <= 1'b0;
        send_word(1'b1, 32'd50000, 32'd40000, 32'd60000);
        send_word(1'b1, 32'd50000 + 32'h7FFF_FFFF, 32'd50000, 32'd60000);

        for (blk = 0; blk < 12; blk++) begin
            wait_results_drained();
            case (blk % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 76; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 76; end
                default: begin send_idle_pct = 8; stall_pct = 8; end
            endcase
            case (blk)
                0: begin
                    write_reg(CFG_SEGMENT_SIZE, 32'd1460);
                    write_reg(CFG_INITIAL_WINDOW, 32'd1460);
                    write_reg(CFG_INITIAL_THRESHOLD, 32'd65535);
                end
                1: begin
                    write_reg(CFG_SEGMENT_SIZE, 32'd65535);
                    write_reg(CFG_INITIAL_WINDOW, 32'hFFFF_FFFF);
                    write_reg(CFG_INITIAL_THRESHOLD, 32'hFFFF_FFFF);
                end
                2: begin
                    write_reg(CFG_SEGMENT_SIZE, 32'd1);
                    write_reg(CFG_INITIAL_WINDOW, 32'd1);
                    write_reg(CFG_INITIAL_THRESHOLD, 32'd0);
                end
                3: begin
                    write_reg(CFG_SEGMENT_SIZE, 32'd65535);
                    write_reg(CFG_INITIAL_WINDOW, 32'd1);
                    write_reg(CFG_INITIAL_THRESHOLD, 32'd0);
                    write_reg(CFG_UNUSED, $urandom());
                end
                4: begin
                    write_reg(CFG_SEGMENT_SIZE, 32'd0);
                end
                default: begin
                    write_reg(CFG_SEGMENT_SIZE, ($urandom_range(0, 3) == 0) ?
                              $urandom_range(1, 65535) : $urandom_range(1, 3000));
                    if ($urandom_range(0, 1))
                        write_reg(CFG_INITIAL_WINDOW, $urandom());
                    if ($urandom_range(0, 1))
                        write_reg(CFG_INITIAL_THRESHOLD, $urandom());
                end
            endcase
            cfg_wr_en <= 1'b0;
            snd_una = $urandom();
            snd_nxt = snd_una + $urandom_range(0, 100000);
            done = 0;
            while (done < 85) begin
                send_random_segment(counted);
                done += counted;
            end
        end

        wait_results_drained();
        repeat (40) @(posedge aclk);
        if (n_fail == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
